### src/mwf_pkg.sv
// Shared types, constants and helpers for the median window filter.
// Used by the interfaces, the register file, the window builder and the sorter.
// No dependencies.
`default_nettype none

package mwf_pkg;

  // Default build limits
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_RADIUS = 2;

  // Field widths
  localparam int PIX_W  = 8;
  localparam int RAD_W  = 2;
  localparam int DIM_W  = 11;
  // Wide enough for the largest supported MAX_WIDTH / MAX_HEIGHT (8192)
  localparam int LIM_W  = 14;
  // Wide enough for MAX_WIDTH * MAX_HEIGHT at the largest supported limits
  localparam int CNT_W  = 27;

  // APB port
  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_e;

  // Input item opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Effective (clamped) configuration and derived frame figures
  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [LIM_W-1:0] width;
    logic [LIM_W-1:0] height;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] lag;
  } cfg_t;

  // Clamp a frame dimension: zero acts as one, above the limit acts as the limit
  function automatic logic [LIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] raw,
                                                 input logic [LIM_W-1:0] lim);
    logic [LIM_W-1:0] v;
    v = LIM_W'(raw);
    if (v == '0) begin
      v = LIM_W'(1);
    end else if (v > lim) begin
      v = lim;
    end
    return v;
  endfunction

  // Clamp the window radius in the same way
  function automatic logic [RAD_W-1:0] clamp_rad(input logic [RAD_W-1:0] raw,
                                                 input logic [RAD_W-1:0] lim);
    logic [RAD_W-1:0] v;
    v = raw;
    if (v == '0) begin
      v = RAD_W'(1);
    end else if (v > lim) begin
      v = lim;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### src/mwf_if.sv
// Stream channel interfaces of the median window filter: pixel input and result output.
// Depends on mwf_pkg for field widths.
`default_nettype none

interface mwf_in_if
  import mwf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             op;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output op, output pixel, input ready);
  modport sink   (input valid, input op, input pixel, output ready);
endinterface

interface mwf_out_if
  import mwf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] median;
  logic             frame_end;

  modport source (output valid, output median, output frame_end, input ready);
  modport sink   (input valid, input median, input frame_end, output ready);
endinterface

`default_nettype wire

### src/median_window_filter.sv
// Top level of the streaming 3x3 / 5x5 median filter.
// Depends on mwf_pkg, mwf_if, mwf_apb_regs, mwf_window, mwf_median (and mwf_ram below).
//
//   channel   | dir | transfer when          | payload
//   ----------+-----+------------------------+------------------------------
//   pix_i     | in  | valid && ready         | op, pixel
//   med_o     | out | valid && ready         | median, frame_end
//   APB       | in  | psel && penable && pw. | window_radius, frame_width,
//             |     |                        | frame_height at 0x0/0x4/0x8
//
// One item per clock sustained while med_o is not stalled; a result passes the
// address, line-store read, compare, rank and select stages in order before it
// is valid on med_o.
// Reset clears control state only; line stores need no clearing pass.
// Every stage holds under a stall and takes new data as soon as it drains.
`default_nettype none

module median_window_filter
  import mwf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [APB_AW-1:0] paddr,
  input  wire  [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  mwf_in_if.sink            pix_i,
  mwf_out_if.source         med_o
);

  localparam int NB   = 2 * MAX_RADIUS + 1;
  localparam int NWIN = NB * NB;

  cfg_t             cfg;
  logic             cfg_wr;
  logic             win_valid, win_ready, win_end;
  logic [PIX_W-1:0] win [NWIN];

  // Configuration registers
  mwf_apb_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg_o    (cfg),
    .cfg_wr_o (cfg_wr)
  );

  // Positions, line stores and window
  mwf_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cfg_wr_i    (cfg_wr),
    .pix_i       (pix_i),
    .win_valid_o (win_valid),
    .win_ready_i (win_ready),
    .win_o       (win),
    .win_end_o   (win_end)
  );

  // Median selection and output register
  mwf_median #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_median (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_valid_i (win_valid),
    .win_ready_o (win_ready),
    .win_i       (win),
    .win_end_i   (win_end),
    .med_o       (med_o)
  );

`ifndef ASSERT_OFF
  a_rad_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr[APB_AW-1:2] == REG_RADIUS) |=>
      (cfg.rad == clamp_rad($past(pwdata[RAD_W-1:0]), RAD_W'(MAX_RADIUS))))
    else $error("radius write not reflected in effective radius");

  a_width_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr[APB_AW-1:2] == REG_WIDTH) |=>
      (cfg.width == clamp_dim($past(pwdata[DIM_W-1:0]), LIM_W'(MAX_WIDTH))))
    else $error("width write not reflected in effective width");

  a_total_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (cfg.total == CNT_W'(cfg.width) * CNT_W'(cfg.height)))
    else $error("pixel total out of step with frame size");
`endif

endmodule

`default_nettype wire

### src/mwf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the line stores.
`default_nettype none

module mwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the contents before a same-edge write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/mwf_apb_regs.sv
// APB configuration registers and derived frame figures (clamped sizes, pixel total, lag).
// Depends on mwf_pkg.
`default_nettype none

module mwf_apb_regs
  import mwf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [APB_AW-1:0]  paddr,
  input  wire  [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  output cfg_t               cfg_o,
  output logic               cfg_wr_o
);

  localparam logic [LIM_W-1:0] W_LIM = LIM_W'(MAX_WIDTH);
  localparam logic [LIM_W-1:0] H_LIM = LIM_W'(MAX_HEIGHT);
  localparam logic [RAD_W-1:0] R_LIM = RAD_W'(MAX_RADIUS);

  localparam int RST_W   = (512 > MAX_WIDTH) ? MAX_WIDTH : 512;
  localparam int RST_H   = (512 > MAX_HEIGHT) ? MAX_HEIGHT : 512;
  localparam int RST_TOT = RST_W * RST_H;
  localparam int RST_LAG = RST_W + 1;

  logic [RAD_W-1:0] rad_q, rad_d;
  logic [DIM_W-1:0] width_q, width_d;
  logic [DIM_W-1:0] height_q, height_d;
  cfg_t             cfg_q, cfg_d;
  logic             wr_en;
  logic [LIM_W-1:0] w_eff, h_eff;
  logic [RAD_W-1:0] r_eff;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register write decode
  always_comb begin
    rad_d    = rad_q;
    width_d  = width_q;
    height_d = height_q;
    cfg_wr_o = 1'b0;
    if (wr_en) begin
      case (reg_idx_e'(paddr[APB_AW-1:2]))
        REG_RADIUS: begin
          rad_d    = pwdata[RAD_W-1:0];
          cfg_wr_o = 1'b1;
        end
        REG_WIDTH: begin
          width_d  = pwdata[DIM_W-1:0];
          cfg_wr_o = 1'b1;
        end
        REG_HEIGHT: begin
          height_d = pwdata[DIM_W-1:0];
          cfg_wr_o = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Derived figures follow the next register values, so they are valid
  // right after the write edge
  always_comb begin
    r_eff        = clamp_rad(rad_d, R_LIM);
    w_eff        = clamp_dim(width_d, W_LIM);
    h_eff        = clamp_dim(height_d, H_LIM);
    cfg_d.rad    = r_eff;
    cfg_d.width  = w_eff;
    cfg_d.height = h_eff;
    cfg_d.total  = CNT_W'(w_eff) * CNT_W'(h_eff);
    cfg_d.lag    = CNT_W'(w_eff) * CNT_W'(r_eff) + CNT_W'(r_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q        <= RAD_W'(1);
      width_q      <= DIM_W'(512);
      height_q     <= DIM_W'(512);
      cfg_q.rad    <= RAD_W'(1);
      cfg_q.width  <= LIM_W'(RST_W);
      cfg_q.height <= LIM_W'(RST_H);
      cfg_q.total  <= CNT_W'(RST_TOT);
      cfg_q.lag    <= CNT_W'(RST_LAG);
    end else begin
      rad_q    <= rad_d;
      width_q  <= width_d;
      height_q <= height_d;
      cfg_q    <= cfg_d;
    end
  end

  // Read back raw register values
  always_comb begin
    prdata = '0;
    case (reg_idx_e'(paddr[APB_AW-1:2]))
      REG_RADIUS: prdata = APB_DW'(rad_q);
      REG_WIDTH:  prdata = APB_DW'(width_q);
      REG_HEIGHT: prdata = APB_DW'(height_q);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### src/mwf_window.sv
// Frame position tracking, line stores and window assembly (two pipeline stages).
// Depends on mwf_pkg, mwf_in_if and mwf_ram.
`default_nettype none

module mwf_window
  import mwf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  localparam int NB        = 2 * MAX_RADIUS + 1,
  localparam int NWIN      = NB * NB
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  cfg_t              cfg_i,
  input  wire               cfg_wr_i,
  mwf_in_if.sink            pix_i,
  output logic              win_valid_o,
  input  wire               win_ready_i,
  output logic [PIX_W-1:0]  win_o [NWIN],
  output logic              win_end_o
);

  localparam int STORE_ROWS = 2 * MAX_RADIUS + 2;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int RING_W     = $clog2(STORE_ROWS);
  localparam int POS_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int CS_W       = COL_W + 2;
  localparam int RS_W       = ROW_W + 2;
  localparam int SUM_W      = RING_W + 3;

  // Frame figures narrowed to this build
  logic [COL_W:0]   w;
  logic [ROW_W:0]   h;
  logic [POS_W-1:0] total, lag;
  logic [CS_W-1:0]  w_m1;
  logic [RS_W-1:0]  h_m1;

  assign w     = cfg_i.width[COL_W:0];
  assign h     = cfg_i.height[ROW_W:0];
  assign total = cfg_i.total[POS_W-1:0];
  assign lag   = cfg_i.lag[POS_W-1:0];
  assign w_m1  = CS_W'(w) - CS_W'(1);
  assign h_m1  = RS_W'(h) - RS_W'(1);

  // Position counters
  logic [POS_W-1:0]  in_cnt_q, out_cnt_q;
  logic [COL_W-1:0]  in_col_q, out_col_q;
  logic [RING_W-1:0] in_ring_q, out_ring_q;
  logic [ROW_W-1:0]  out_row_q;

  // Pipeline handshake
  logic s1_v_q, s2_v_q;
  logic s1_ready, s2_ready, s2_load, acc;

  assign s2_ready    = !s2_v_q || win_ready_i;
  assign s1_ready    = !s1_v_q || s2_ready;
  assign s2_load     = s1_v_q && s2_ready;
  assign pix_i.ready = s1_ready;
  assign acc         = pix_i.valid && s1_ready;

  // Per-item decision
  logic             pix_phase, is_flush, wr_en, try_out, out_done, last, emit, clr;
  logic [POS_W-1:0] in_cnt_inc;

  always_comb begin
    pix_phase  = in_cnt_q < total;
    is_flush   = pix_i.op == OP_FLUSH;
    wr_en      = acc && pix_phase && !is_flush;
    in_cnt_inc = in_cnt_q + POS_W'(1);
    try_out    = !pix_phase || (!is_flush && (in_cnt_inc > lag));
    out_done   = out_cnt_q >= total;
    last       = (out_cnt_q + POS_W'(1)) == total;
    emit       = acc && try_out && !out_done;
    clr        = acc && try_out && (out_done || last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q   <= '0;
      in_col_q   <= '0;
      in_ring_q  <= '0;
      out_cnt_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_ring_q <= '0;
    end else if (cfg_wr_i || clr) begin
      in_cnt_q   <= '0;
      in_col_q   <= '0;
      in_ring_q  <= '0;
      out_cnt_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_ring_q <= '0;
    end else begin
      if (wr_en) begin
        in_cnt_q <= in_cnt_inc;
        if ((COL_W + 1)'(in_col_q) + (COL_W + 1)'(1) == w) begin
          in_col_q  <= '0;
          in_ring_q <= (in_ring_q == RING_W'(STORE_ROWS - 1)) ? '0 : in_ring_q + RING_W'(1);
        end else begin
          in_col_q <= in_col_q + COL_W'(1);
        end
      end
      if (emit) begin
        out_cnt_q <= out_cnt_q + POS_W'(1);
        if ((COL_W + 1)'(out_col_q) + (COL_W + 1)'(1) == w) begin
          out_col_q  <= '0;
          out_row_q  <= out_row_q + ROW_W'(1);
          out_ring_q <= (out_ring_q == RING_W'(STORE_ROWS - 1)) ? '0 :
                        out_ring_q + RING_W'(1);
        end else begin
          out_col_q <= out_col_q + COL_W'(1);
        end
      end
    end
  end

  // Clamped window geometry of the output pixel: one column per bank,
  // one line-store ring slot per window row
  logic [COL_W-1:0]  col_sel  [NB];
  logic [RING_W-1:0] ring_sel [NB];

  always_comb begin
    logic signed [CS_W-1:0] cs;
    logic signed [RS_W-1:0] rs;
    logic signed [RS_W-1:0] roff;
    logic [SUM_W-1:0]       rsum;
    for (int d = 0; d < NB; d++) begin
      cs = $signed({2'b00, out_col_q}) + CS_W'(d - MAX_RADIUS);
      if (cs < 0) begin
        col_sel[d] = '0;
      end else if ($unsigned(cs) > w_m1) begin
        col_sel[d] = w_m1[COL_W-1:0];
      end else begin
        col_sel[d] = cs[COL_W-1:0];
      end

      rs = $signed({2'b00, out_row_q}) + RS_W'(d - MAX_RADIUS);
      if (rs < 0) begin
        rs = '0;
      end else if ($unsigned(rs) > h_m1) begin
        rs = $signed(h_m1);
      end
      roff = rs - $signed({2'b00, out_row_q});
      rsum = SUM_W'(out_ring_q) + SUM_W'(STORE_ROWS) + SUM_W'(roff);
      if (rsum >= SUM_W'(2 * STORE_ROWS)) begin
        rsum = rsum - SUM_W'(2 * STORE_ROWS);
      end else if (rsum >= SUM_W'(STORE_ROWS)) begin
        rsum = rsum - SUM_W'(STORE_ROWS);
      end
      ring_sel[d] = rsum[RING_W-1:0];
    end
  end

  // Stage 1: addresses for the line-store reads
  logic [COL_W-1:0]  s1_col_q  [NB];
  logic [RING_W-1:0] s1_ring_q [NB];
  logic [RAD_W-1:0]  s1_rad_q;
  logic              s1_end_q;

  // Stage 2: read data comes back registered from the stores
  logic [RING_W-1:0] s2_ring_q [NB];
  logic [RAD_W-1:0]  s2_rad_q;
  logic              s2_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= emit;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_col_q  <= col_sel;
      s1_ring_q <= ring_sel;
      s1_rad_q  <= cfg_i.rad;
      s1_end_q  <= last;
    end
    if (s2_load) begin
      s2_ring_q <= s1_ring_q;
      s2_rad_q  <= s1_rad_q;
      s2_end_q  <= s1_end_q;
    end
  end

  // Line stores: one copy per window column, one RAM per stored row
  logic [PIX_W-1:0] rd [NB][STORE_ROWS];

  for (genvar b = 0; b < NB; b++) begin : g_bank
    for (genvar s = 0; s < STORE_ROWS; s++) begin : g_row
      mwf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
      ) u_ram (
        .clk_i   (clk_i),
        .we_i    (wr_en && (in_ring_q == RING_W'(s))),
        .waddr_i (in_col_q),
        .wdata_i (pix_i.pixel),
        .re_i    (s2_load),
        .raddr_i (s1_col_q[b]),
        .rdata_o (rd[b][s])
      );
    end
  end

  // Window assembly; slots outside a smaller window are padded with equal
  // numbers of black and white so the middle rank is unchanged
  for (genvar a = 0; a < NB; a++) begin : g_wrow
    for (genvar b = 0; b < NB; b++) begin : g_wcol
      localparam int DA = (a >= MAX_RADIUS) ? a - MAX_RADIUS : MAX_RADIUS - a;
      localparam int DB = (b >= MAX_RADIUS) ? b - MAX_RADIUS : MAX_RADIUS - b;
      localparam int K  = a * NB + b;
      localparam logic [PIX_W-1:0] PAD = (K < NWIN / 2) ? '0 : '1;
      assign win_o[K] = (RAD_W'(DA) <= s2_rad_q && RAD_W'(DB) <= s2_rad_q) ?
                        rd[b][s2_ring_q[a]] : PAD;
    end
  end

  assign win_valid_o = s2_v_q;
  assign win_end_o   = s2_end_q;

endmodule

`default_nettype wire

### src/mwf_median.sv
// Rank-based median selection over the window: compare, rank, select (three stages).
// Depends on mwf_pkg and mwf_out_if.
`default_nettype none

module mwf_median
  import mwf_pkg::*;
#(
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  localparam int N         = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1)
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               win_valid_i,
  output logic              win_ready_o,
  input  wire  [PIX_W-1:0]  win_i [N],
  input  wire               win_end_i,
  mwf_out_if.source         med_o
);

  localparam int MID = N / 2;

  logic s3_v_q, s4_v_q, s5_v_q;
  logic s3_ready, s4_ready, s5_ready;

  assign s5_ready    = !s5_v_q || med_o.ready;
  assign s4_ready    = !s4_v_q || s5_ready;
  assign s3_ready    = !s3_v_q || s4_ready;
  assign win_ready_o = s3_ready;

  // Precedence matrix: bit j of row i is set when element j sorts before i
  // (ties broken by slot index, so every element has a distinct rank)
  logic [N-1:0] prec [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        if (j == i) begin
          prec[i][j] = 1'b0;
        end else begin
          prec[i][j] = (win_i[j] < win_i[i]) || ((win_i[j] == win_i[i]) && (j < i));
        end
      end
    end
  end

  // Stage 3: comparisons
  logic [PIX_W-1:0] s3_val_q [N];
  logic [N-1:0]     s3_prec_q [N];
  logic             s3_end_q;

  // Stage 4: one-hot pick of the middle rank
  logic [PIX_W-1:0] s4_val_q [N];
  logic [N-1:0]     s4_sel_q;
  logic             s4_end_q;
  logic [N-1:0]     sel_d;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      sel_d[i] = $countones(s3_prec_q[i]) == MID;
    end
  end

  // Stage 5: output register
  logic [PIX_W-1:0] med_q, med_d;
  logic             end_q;

  always_comb begin
    med_d = '0;
    for (int i = 0; i < N; i++) begin
      med_d = med_d | (s4_val_q[i] & {PIX_W{s4_sel_q[i]}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_v_q <= win_valid_i;
      end
      if (s4_ready) begin
        s4_v_q <= s3_v_q;
      end
      if (s5_ready) begin
        s5_v_q <= s4_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_valid_i && s3_ready) begin
      s3_val_q  <= win_i;
      s3_prec_q <= prec;
      s3_end_q  <= win_end_i;
    end
    if (s3_v_q && s4_ready) begin
      s4_val_q <= s3_val_q;
      s4_sel_q <= sel_d;
      s4_end_q <= s3_end_q;
    end
    if (s4_v_q && s5_ready) begin
      med_q <= med_d;
      end_q <= s4_end_q;
    end
  end

  assign med_o.valid     = s5_v_q;
  assign med_o.median    = med_q;
  assign med_o.frame_end = end_q;

endmodule

`default_nettype wire
